FILE: rtl/rsttok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsttok_pkg;

   localparam int DEVICE_NAME_MAX  = 16;
   localparam int COMMAND_NAME_MAX = 15;
   localparam int RESULT_CAP       = 17;
   localparam int TAIL_MAX         = 3;
   localparam int QUEUE_DEPTH      = 4;

   localparam int LA_CNT_W   = $clog2(DEVICE_NAME_MAX + 1);
   localparam int LA_IDX_W   = (DEVICE_NAME_MAX > 1) ? $clog2(DEVICE_NAME_MAX) : 1;
   localparam int CMD_LEN_W  = $clog2(COMMAND_NAME_MAX + 1);
   localparam int POS_W      = $clog2(RESULT_CAP);
   localparam int TAIL_CNT_W = 2;
   localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] CHAR_AMP  = 8'h26;
   localparam logic [7:0] CHAR_PIPE = 8'h7C;
   localparam logic [7:0] CHAR_BSL  = 8'h5C;

   typedef enum logic [2:0] {
      TK_DEV_BYTE = 3'd0,
      TK_DEV_END  = 3'd1,
      TK_CMD_BYTE = 3'd2,
      TK_CMD_END  = 3'd3,
      TK_PAR_BYTE = 3'd4,
      TK_PAR_END  = 3'd5,
      TK_REQ_END  = 3'd6
   } token_kind_type;

   typedef enum logic [2:0] {
      PH_LOOK  = 3'b001,
      PH_CMD   = 3'b010,
      PH_PARAM = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      ESC_NONE = 3'b001,
      ESC_HIGH = 3'b010,
      ESC_LOW  = 3'b100
   } esc_type;

   typedef struct packed {
      token_kind_type kind;
      logic [7:0]     value;
   } token_type;

   // one queue entry: optional lookahead write, a replay of held bytes, then tail tokens
   typedef struct packed {
      logic                           wr_en;
      logic [LA_IDX_W-1:0]            wr_addr;
      logic [7:0]                     wr_data;
      token_kind_type                 rep_kind;
      logic [LA_CNT_W-1:0]            rep_n;
      logic [TAIL_CNT_W-1:0]          tail_n;
      token_type [TAIL_MAX-1:0]       tail;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
         d = c - 8'h30;
      end else if (c inside {[8'h41:8'h46]}) begin
         d = c - 8'h37;
      end
      return d[3:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/rsttok_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rsttok_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       char_in,
   output rsttok_pkg::op_type    op_out
);

   rsttok_pkg::phase_type                    phase_ff, phase_in;
   logic [rsttok_pkg::LA_CNT_W-1:0]          la_count_ff, la_count_in;
   logic [rsttok_pkg::CMD_LEN_W-1:0]         cmd_len_ff, cmd_len_in;
   rsttok_pkg::esc_type                      esc_ff, esc_in;
   logic [3:0]                               high_ff, high_in;

   rsttok_pkg::op_type                       op;
   logic [rsttok_pkg::CMD_LEN_W-1:0]         cmd_len_use;
   logic                                     do_cmd;
   logic                                     is_sep;
   logic [7:0]                               pend_val;

   always_comb begin
      if (phase_ff == rsttok_pkg::PH_LOOK) begin
         if (int'(la_count_ff) > rsttok_pkg::COMMAND_NAME_MAX) begin
            cmd_len_use = rsttok_pkg::CMD_LEN_W'(rsttok_pkg::COMMAND_NAME_MAX);
         end else begin
            cmd_len_use = rsttok_pkg::CMD_LEN_W'(la_count_ff);
         end
      end else begin
         cmd_len_use = cmd_len_ff;
      end
   end

   assign is_sep   = char_in inside {rsttok_pkg::CHAR_AMP, rsttok_pkg::CHAR_PIPE,
                                     rsttok_pkg::CHAR_NUL};
   assign pend_val = (esc_ff == rsttok_pkg::ESC_LOW) ? {high_ff, 4'h0} : 8'h00;

   always_comb begin
      phase_in    = phase_ff;
      la_count_in = la_count_ff;
      cmd_len_in  = cmd_len_ff;
      esc_in      = esc_ff;
      high_in     = high_ff;
      op          = '0;
      op.rep_kind = rsttok_pkg::TK_CMD_BYTE;
      do_cmd      = 1'b0;

      case (phase_ff)
         rsttok_pkg::PH_LOOK: begin
            if (char_in == rsttok_pkg::CHAR_PIPE) begin
               op.rep_kind       = rsttok_pkg::TK_DEV_BYTE;
               op.rep_n          = la_count_ff;
               op.tail[0].kind   = rsttok_pkg::TK_DEV_END;
               op.tail_n         = rsttok_pkg::TAIL_CNT_W'(1);
               la_count_in       = '0;
               cmd_len_in        = '0;
               phase_in          = rsttok_pkg::PH_CMD;
            end else if (char_in inside {rsttok_pkg::CHAR_NUL, rsttok_pkg::CHAR_AMP} ||
                         int'(la_count_ff) >= rsttok_pkg::DEVICE_NAME_MAX) begin
               // no device: replay held bytes as command, then this char as command
               op.rep_kind = rsttok_pkg::TK_CMD_BYTE;
               op.rep_n    = rsttok_pkg::LA_CNT_W'(cmd_len_use);
               la_count_in = '0;
               do_cmd      = 1'b1;
            end else begin
               op.wr_en    = 1'b1;
               op.wr_addr  = rsttok_pkg::LA_IDX_W'(la_count_ff);
               op.wr_data  = char_in;
               la_count_in = la_count_ff + rsttok_pkg::LA_CNT_W'(1);
            end
         end
         rsttok_pkg::PH_CMD: begin
            do_cmd = 1'b1;
         end
         rsttok_pkg::PH_PARAM: begin
            if (is_sep) begin
               if (esc_ff != rsttok_pkg::ESC_NONE) begin
                  op.tail[0].kind  = rsttok_pkg::TK_PAR_BYTE;
                  op.tail[0].value = pend_val;
                  op.tail[1].kind  = rsttok_pkg::TK_PAR_END;
                  op.tail[2].kind  = rsttok_pkg::TK_REQ_END;
                  op.tail_n        = (char_in == rsttok_pkg::CHAR_NUL) ?
                                     rsttok_pkg::TAIL_CNT_W'(3) : rsttok_pkg::TAIL_CNT_W'(2);
               end else begin
                  op.tail[0].kind  = rsttok_pkg::TK_PAR_END;
                  op.tail[1].kind  = rsttok_pkg::TK_REQ_END;
                  op.tail_n        = (char_in == rsttok_pkg::CHAR_NUL) ?
                                     rsttok_pkg::TAIL_CNT_W'(2) : rsttok_pkg::TAIL_CNT_W'(1);
               end
               esc_in  = rsttok_pkg::ESC_NONE;
               high_in = 4'h0;
               if (char_in == rsttok_pkg::CHAR_PIPE) begin
                  cmd_len_in = '0;
                  phase_in   = rsttok_pkg::PH_CMD;
               end else if (char_in == rsttok_pkg::CHAR_NUL) begin
                  phase_in    = rsttok_pkg::PH_LOOK;
                  la_count_in = '0;
                  cmd_len_in  = '0;
               end
            end else if (esc_ff == rsttok_pkg::ESC_HIGH) begin
               high_in = rsttok_pkg::hex_nibble(char_in);
               esc_in  = rsttok_pkg::ESC_LOW;
            end else if (esc_ff == rsttok_pkg::ESC_LOW) begin
               op.tail[0].kind  = rsttok_pkg::TK_PAR_BYTE;
               op.tail[0].value = {high_ff, rsttok_pkg::hex_nibble(char_in)};
               op.tail_n        = rsttok_pkg::TAIL_CNT_W'(1);
               esc_in           = rsttok_pkg::ESC_NONE;
               high_in          = 4'h0;
            end else if (char_in == rsttok_pkg::CHAR_BSL) begin
               esc_in = rsttok_pkg::ESC_HIGH;
            end else begin
               op.tail[0].kind  = rsttok_pkg::TK_PAR_BYTE;
               op.tail[0].value = char_in;
               op.tail_n        = rsttok_pkg::TAIL_CNT_W'(1);
            end
         end
         default: begin
            phase_in    = rsttok_pkg::PH_LOOK;
            la_count_in = '0;
            cmd_len_in  = '0;
            esc_in      = rsttok_pkg::ESC_NONE;
            high_in     = 4'h0;
         end
      endcase

      if (do_cmd) begin
         phase_in = rsttok_pkg::PH_CMD;
         if (char_in == rsttok_pkg::CHAR_AMP) begin
            op.tail[0].kind = rsttok_pkg::TK_CMD_END;
            op.tail_n       = rsttok_pkg::TAIL_CNT_W'(1);
            cmd_len_in      = '0;
            esc_in          = rsttok_pkg::ESC_NONE;
            high_in         = 4'h0;
            phase_in        = rsttok_pkg::PH_PARAM;
         end else if (char_in == rsttok_pkg::CHAR_PIPE) begin
            op.tail[0].kind = rsttok_pkg::TK_CMD_END;
            op.tail_n       = rsttok_pkg::TAIL_CNT_W'(1);
            cmd_len_in      = '0;
         end else if (char_in == rsttok_pkg::CHAR_NUL) begin
            op.tail[0].kind = rsttok_pkg::TK_CMD_END;
            op.tail[1].kind = rsttok_pkg::TK_REQ_END;
            op.tail_n       = rsttok_pkg::TAIL_CNT_W'(2);
            phase_in        = rsttok_pkg::PH_LOOK;
            la_count_in     = '0;
            cmd_len_in      = '0;
            esc_in          = rsttok_pkg::ESC_NONE;
            high_in         = 4'h0;
         end else if (int'(cmd_len_use) < rsttok_pkg::COMMAND_NAME_MAX) begin
            op.tail[0].kind  = rsttok_pkg::TK_CMD_BYTE;
            op.tail[0].value = char_in;
            op.tail_n        = rsttok_pkg::TAIL_CNT_W'(1);
            cmd_len_in       = cmd_len_use + rsttok_pkg::CMD_LEN_W'(1);
         end else begin
            cmd_len_in = cmd_len_use;
         end
      end
   end

   // per-char result cap
   always_comb begin
      int room;
      op_out = op;
      if (int'(op.rep_n) > rsttok_pkg::RESULT_CAP) begin
         op_out.rep_n = rsttok_pkg::LA_CNT_W'(rsttok_pkg::RESULT_CAP);
      end
      room = rsttok_pkg::RESULT_CAP - int'(op_out.rep_n);
      if (int'(op.tail_n) > room) begin
         op_out.tail_n = rsttok_pkg::TAIL_CNT_W'(room);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= rsttok_pkg::PH_LOOK;
         la_count_ff <= '0;
         cmd_len_ff  <= '0;
         esc_ff      <= rsttok_pkg::ESC_NONE;
         high_ff     <= 4'h0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         la_count_ff <= la_count_in;
         cmd_len_ff  <= cmd_len_in;
         esc_ff      <= esc_in;
         high_ff     <= high_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rsttok_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module rsttok_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  rsttok_pkg::op_type       push_op,
   input  wire logic                pop,
   output rsttok_pkg::op_type       head_op,
   output rsttok_pkg::q_status_type status
);

   rsttok_pkg::op_type                  mem_ff [rsttok_pkg::QUEUE_DEPTH];
   logic [rsttok_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rsttok_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rsttok_pkg::QCNT_W-1:0]       count_ff, count_in;

   function automatic logic [rsttok_pkg::QPTR_W-1:0] next_ptr(
      input logic [rsttok_pkg::QPTR_W-1:0] p);
      if (int'(p) == rsttok_pkg::QUEUE_DEPTH - 1) begin
         return '0;
      end
      return p + rsttok_pkg::QPTR_W'(1);
   endfunction

   assign status.full  = (int'(count_ff) == rsttok_pkg::QUEUE_DEPTH);
   assign status.empty = (count_ff == '0);
   assign head_op      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + rsttok_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - rsttok_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rsttok_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rsttok_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  rsttok_pkg::op_type     op_in,
   input  wire logic              op_valid,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic [2:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   logic [7:0]                        la_buf_ff [rsttok_pkg::DEVICE_NAME_MAX];
   logic [rsttok_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic                              valid_ff, valid_in;
   rsttok_pkg::token_kind_type        kind_ff, kind_in;
   logic [7:0]                        value_ff, value_in;
   logic                              last_ff, last_in;

   int                                total;
   logic                              adv;
   logic                              emit;
   logic [rsttok_pkg::LA_IDX_W-1:0]   rd_idx;
   logic [rsttok_pkg::TAIL_CNT_W-1:0] tail_idx;
   rsttok_pkg::token_type             tail_tok;

   assign total    = int'(op_in.rep_n) + int'(op_in.tail_n);
   assign adv      = !valid_ff || rsp_tready;
   assign rd_idx   = rsttok_pkg::LA_IDX_W'(pos_ff);
   assign tail_idx = rsttok_pkg::TAIL_CNT_W'(int'(pos_ff) - int'(op_in.rep_n));

   always_comb begin
      case (tail_idx)
         2'd1:    tail_tok = op_in.tail[1];
         2'd2:    tail_tok = op_in.tail[2];
         default: tail_tok = op_in.tail[0];
      endcase
   end

   always_comb begin
      emit = 1'b0;
      pop  = 1'b0;
      if (op_valid) begin
         if (total == 0) begin
            pop = 1'b1;
         end else if (adv) begin
            emit = 1'b1;
            pop  = (int'(pos_ff) == total - 1);
         end
      end

      pos_in = pos_ff;
      if (emit) begin
         pos_in = pop ? '0 : pos_ff + rsttok_pkg::POS_W'(1);
      end

      valid_in = valid_ff;
      kind_in  = kind_ff;
      value_in = value_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         last_in  = pop;
         if (int'(pos_ff) < int'(op_in.rep_n)) begin
            kind_in  = op_in.rep_kind;
            value_in = la_buf_ff[rd_idx];
         end else begin
            kind_in  = tail_tok.kind;
            value_in = tail_tok.value;
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      last_ff  <= last_in;
      if (pop && op_in.wr_en) begin
         la_buf_ff[op_in.wr_addr] <= op_in.wr_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = value_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

FILE: rtl/request_string_tokenizer.sv
// Request string tokenizer.
// req channel: one request character per beat in req_tdata; a NUL ends the request.
// rsp channel: one token per beat; rsp_tuser gives the token kind, rsp_tdata the byte
// (zero for end markers), rsp_tlast marks the last token caused by one character.
// A front end classifies each character and writes one entry into a four-deep queue;
// a back end holds the 16-byte lookahead buffer and plays entries out of an output
// register, one token per cycle while rsp_tready is high or the register is empty.
// The tokens of a character pass through the queue and then the output register.
// Throughput: one character per cycle while each makes at most one token and rsp_tready
// is high; a character that makes several tokens (at most 17, for a device name or a
// lookahead replay) holds the back end until all are out; tokenless ones drain one per cycle.
// req_tready drops only when the queue is full.
// When rsp_tready is low the output register holds its beat; the queue keeps
// taking characters until it fills.
// Reset clears the parse state, the queue and the output valid; the block is then at
// the start of a request.
`timescale 1ns / 1ps
`default_nettype none

module request_string_tokenizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] token_byte
   output logic [2:0]       rsp_tuser,   // [2:0] token_kind
   output logic             rsp_tlast
);

   rsttok_pkg::op_type        front_op;
   rsttok_pkg::op_type        head_op;
   rsttok_pkg::q_status_type  q_status;
   logic                      accept;
   logic                      pop;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   rsttok_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .char_in (req_tdata),
      .op_out  (front_op)
   );

   rsttok_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .push_op (front_op),
      .pop     (pop),
      .head_op (head_op),
      .status  (q_status)
   );

   rsttok_back u_back (
      .clock      (clock),
      .reset      (reset),
      .op_in      (head_op),
      .op_valid   (!q_status.empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == rsttok_pkg::TK_DEV_END || rsp_tuser == rsttok_pkg::TK_CMD_END ||
                     rsp_tuser == rsttok_pkg::TK_PAR_END || rsp_tuser == rsttok_pkg::TK_REQ_END)
      |-> rsp_tdata == 8'h00)
      else $error("end marker with nonzero byte");

   a_req_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == rsttok_pkg::TK_REQ_END |-> rsp_tlast)
      else $error("request end not last token of its beat");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

typedef struct packed {
   rsttok_pkg::token_kind_type kind;
   logic [7:0]                 value;
   logic                       is_last;
} token_beat_type;

class token_scoreboard;
   token_beat_type        expected_q[$];
   token_beat_type        char_q[$];
   rsttok_pkg::phase_type phase;
   logic [7:0]            held[rsttok_pkg::DEVICE_NAME_MAX];
   int unsigned           held_n;
   int unsigned           cmd_len;
   rsttok_pkg::esc_type   esc;
   logic [3:0]            esc_high;
   int unsigned           errors;
   int unsigned           checked;

   function new();
      errors  = 0;
      checked = 0;
      restart();
   endfunction

   function void restart();
      phase    = rsttok_pkg::PH_LOOK;
      held_n   = 0;
      cmd_len  = 0;
      esc      = rsttok_pkg::ESC_NONE;
      esc_high = 4'h0;
   endfunction

   function void emit(rsttok_pkg::token_kind_type k, logic [7:0] v);
      token_beat_type t;
      if (char_q.size() < rsttok_pkg::RESULT_CAP) begin
         t.kind    = k;
         t.value   = v;
         t.is_last = 1'b0;
         char_q.push_back(t);
      end
   endfunction

   function logic [3:0] hex_val(logic [7:0] c);
      if (c inside {[8'h30:8'h39]}) begin
         return c[3:0];
      end else if (c inside {[8'h41:8'h46]}) begin
         return c[3:0] + 4'd9;
      end
      return 4'h0;
   endfunction

   function void cmd_char(logic [7:0] c);
      if (c == rsttok_pkg::CHAR_AMP) begin
         emit(rsttok_pkg::TK_CMD_END, 8'h00);
         cmd_len  = 0;
         esc      = rsttok_pkg::ESC_NONE;
         esc_high = 4'h0;
         phase    = rsttok_pkg::PH_PARAM;
      end else if (c == rsttok_pkg::CHAR_PIPE) begin
         emit(rsttok_pkg::TK_CMD_END, 8'h00);
         cmd_len = 0;
         phase   = rsttok_pkg::PH_CMD;
      end else if (c == rsttok_pkg::CHAR_NUL) begin
         emit(rsttok_pkg::TK_CMD_END, 8'h00);
         emit(rsttok_pkg::TK_REQ_END, 8'h00);
         restart();
      end else if (cmd_len < rsttok_pkg::COMMAND_NAME_MAX) begin
         emit(rsttok_pkg::TK_CMD_BYTE, c);
         cmd_len++;
      end
   endfunction

   function void par_char(logic [7:0] c);
      if (c inside {rsttok_pkg::CHAR_AMP, rsttok_pkg::CHAR_PIPE, rsttok_pkg::CHAR_NUL}) begin
         // separator closes a pending escape with zero nibbles
         if (esc != rsttok_pkg::ESC_NONE) begin
            emit(rsttok_pkg::TK_PAR_BYTE,
                 (esc == rsttok_pkg::ESC_LOW) ? {esc_high, 4'h0} : 8'h00);
         end
         esc      = rsttok_pkg::ESC_NONE;
         esc_high = 4'h0;
         emit(rsttok_pkg::TK_PAR_END, 8'h00);
         if (c == rsttok_pkg::CHAR_PIPE) begin
            cmd_len = 0;
            phase   = rsttok_pkg::PH_CMD;
         end else if (c == rsttok_pkg::CHAR_NUL) begin
            emit(rsttok_pkg::TK_REQ_END, 8'h00);
            restart();
         end
      end else if (esc == rsttok_pkg::ESC_HIGH) begin
         esc_high = hex_val(c);
         esc      = rsttok_pkg::ESC_LOW;
      end else if (esc == rsttok_pkg::ESC_LOW) begin
         emit(rsttok_pkg::TK_PAR_BYTE, {esc_high, hex_val(c)});
         esc      = rsttok_pkg::ESC_NONE;
         esc_high = 4'h0;
      end else if (c == rsttok_pkg::CHAR_BSL) begin
         esc = rsttok_pkg::ESC_HIGH;
      end else begin
         emit(rsttok_pkg::TK_PAR_BYTE, c);
      end
   endfunction

   function void look_char(logic [7:0] c);
      int unsigned n;
      n = (held_n > rsttok_pkg::DEVICE_NAME_MAX) ? rsttok_pkg::DEVICE_NAME_MAX : held_n;
      if (c == rsttok_pkg::CHAR_PIPE) begin
         for (int i = 0; i < n; i++) emit(rsttok_pkg::TK_DEV_BYTE, held[i]);
         emit(rsttok_pkg::TK_DEV_END, 8'h00);
         held_n  = 0;
         cmd_len = 0;
         phase   = rsttok_pkg::PH_CMD;
      end else if (c inside {rsttok_pkg::CHAR_NUL, rsttok_pkg::CHAR_AMP} ||
                   n >= rsttok_pkg::DEVICE_NAME_MAX) begin
         // no device name: held bytes become the first command
         held_n  = 0;
         cmd_len = 0;
         phase   = rsttok_pkg::PH_CMD;
         for (int i = 0; i < n; i++) cmd_char(held[i]);
         cmd_char(c);
      end else begin
         held[n] = c;
         held_n  = n + 1;
      end
   endfunction

   function void note_char(logic [7:0] c);
      char_q.delete();
      case (phase)
         rsttok_pkg::PH_LOOK:  look_char(c);
         rsttok_pkg::PH_CMD:   cmd_char(c);
         rsttok_pkg::PH_PARAM: par_char(c);
         default:              restart();
      endcase
      if (char_q.size() > 0) char_q[char_q.size() - 1].is_last = 1'b1;
      foreach (char_q[i]) expected_q.push_back(char_q[i]);
   endfunction

   function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
   endfunction

   function void check_token(logic [2:0] kind, logic [7:0] value, logic is_last);
      token_beat_type t;
      checked++;
      if (expected_q.size() == 0) begin
         note_error($sformatf("unexpected token kind %0d byte %02h last %0b",
                              kind, value, is_last));
         return;
      end
      t = expected_q.pop_front();
      if (t.kind !== kind || t.value !== value || t.is_last !== is_last) begin
         note_error($sformatf({"token %0d: expected kind %0d byte %02h last %0b, ",
                               "got kind %0d byte %02h last %0b"},
                              checked, t.kind, t.value, t.is_last, kind, value, is_last));
      end
   endfunction
endclass

module tb;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_CHARS = 110;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       rsp_tlast;

   token_scoreboard sb;
   logic [7:0]      req_buf[$];
   int              src_idle_pct = 0;
   int              sink_stall_pct = 0;
   int              cycle_count = 0;
   int              sent_chars = 0;
   int              sent_requests = 0;

   logic [7:0] directed_chars[22] = '{
      rsttok_pkg::CHAR_NUL,
      rsttok_pkg::CHAR_PIPE, rsttok_pkg::CHAR_NUL,
      "X", rsttok_pkg::CHAR_AMP, rsttok_pkg::CHAR_BSL, "4", "1",
      rsttok_pkg::CHAR_BSL, "g", "F",
      rsttok_pkg::CHAR_BSL, rsttok_pkg::CHAR_BSL, rsttok_pkg::CHAR_AMP,
      rsttok_pkg::CHAR_BSL, "B", rsttok_pkg::CHAR_AMP,
      rsttok_pkg::CHAR_BSL, rsttok_pkg::CHAR_PIPE,
      8'hFF, 8'h01, rsttok_pkg::CHAR_NUL
   };

   request_string_tokenizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_token(rsp_tuser, rsp_tdata, rsp_tlast);
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
   end

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do begin
         c = $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A))
                                  : 8'($urandom_range(1, 255));
      end while (c == rsttok_pkg::CHAR_PIPE || c == rsttok_pkg::CHAR_AMP);
      return c;
   endfunction

   function automatic logic [7:0] hex_char();
      int unsigned v;
      v = $urandom_range(0, 15);
      return (v < 10) ? 8'(8'h30 + v) : 8'(8'h37 + v);
   endfunction

   task automatic push_param_item();
      int         r;
      logic [7:0] c;
      r = $urandom_range(0, 9);
      if (r < 5) begin
         do c = plain_char(); while (c == rsttok_pkg::CHAR_BSL);
         req_buf.push_back(c);
      end else if (r < 8) begin
         req_buf.push_back(rsttok_pkg::CHAR_BSL);
         req_buf.push_back(hex_char());
         req_buf.push_back(hex_char());
      end else if (r == 8) begin
         // arbitrary escape digits, mostly outside the hex set, a backslash among them too
         req_buf.push_back(rsttok_pkg::CHAR_BSL);
         req_buf.push_back(plain_char());
         req_buf.push_back($urandom_range(0, 3) == 0 ? rsttok_pkg::CHAR_BSL : plain_char());
      end else begin
         // cut-off escape
         req_buf.push_back(rsttok_pkg::CHAR_BSL);
         if ($urandom_range(0, 1)) req_buf.push_back(hex_char());
      end
   endtask

   task automatic build_request();
      int shape;
      int n_cmd;
      int name_len;
      int n_par;
      req_buf.delete();
      shape = $urandom_range(0, 7);
      if (shape == 0) begin
         repeat ($urandom_range(1, 30)) req_buf.push_back(8'($urandom_range(0, 255)));
         req_buf.push_back(rsttok_pkg::CHAR_NUL);
         return;
      end
      if (shape <= 4) begin
         name_len = ($urandom_range(0, 3) == 0) ? rsttok_pkg::DEVICE_NAME_MAX
                                                : $urandom_range(0, rsttok_pkg::DEVICE_NAME_MAX);
         repeat (name_len) req_buf.push_back(plain_char());
         req_buf.push_back(rsttok_pkg::CHAR_PIPE);
      end else if (shape == 5) begin
         repeat ($urandom_range(rsttok_pkg::DEVICE_NAME_MAX, rsttok_pkg::DEVICE_NAME_MAX + 4)) begin
            req_buf.push_back(plain_char());
         end
      end
      n_cmd = $urandom_range(1, 3);
      for (int i = 0; i < n_cmd; i++) begin
         if (i > 0) req_buf.push_back(rsttok_pkg::CHAR_PIPE);
         if (!(shape == 5 && i == 0)) begin
            name_len = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 20)
                                                   : $urandom_range(0, 8);
            repeat (name_len) req_buf.push_back(plain_char());
         end
         n_par = $urandom_range(0, 3);
         if (shape >= 6 && i == 0 && n_par == 0 && n_cmd > 1) n_par = 1;
         repeat (n_par) begin
            req_buf.push_back(rsttok_pkg::CHAR_AMP);
            repeat ($urandom_range(0, 5)) push_param_item();
         end
      end
      req_buf.push_back(rsttok_pkg::CHAR_NUL);
   endtask

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_char(logic [7:0] c);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_char(c);
      sent_chars++;
      if (c == rsttok_pkg::CHAR_NUL) sent_requests++;
      @(negedge clock);
   endtask

   initial begin
      int phase_start;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_chars[i]) send_char(directed_chars[i]);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 66; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 66; end
            default: begin src_idle_pct = 10; sink_stall_pct = 10; end
         endcase
         phase_start = sent_chars;
         while (sent_chars - phase_start < PHASE_CHARS) begin
            build_request();
            foreach (req_buf[i]) send_char(req_buf[i]);
         end
      end
      req_tvalid <= 1'b0;
      sink_stall_pct = 0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (sb.expected_q.size() != 0) begin
         sb.note_error($sformatf("%0d expected tokens never arrived", sb.expected_q.size()));
      end
      $display("%0d characters in %0d requests sent, %0d tokens checked",
               sent_chars, sent_requests, sb.checked);
      $display("flow control covered free running, sparse sender, stalling receiver, both light");
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("simulation failed");
      end
      $finish;
   end
endmodule

FILE: sim.f
rtl/rsttok_pkg.sv
rtl/rsttok_front.sv
rtl/rsttok_fifo.sv
rtl/rsttok_back.sv
rtl/request_string_tokenizer.sv
sim/tb.sv
